>>> rtl/core/network_program_loader_macros.svh
// Assertion macros shared by the network program loader RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef NETWORK_PROGRAM_LOADER_MACROS_SVH
`define NETWORK_PROGRAM_LOADER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NPL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("network_program_loader: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define NPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("network_program_loader: next-cycle check failed");

`endif

>>> rtl/core/npl_pkg.sv
// Package for the network program loader: command codes, operation codes
// and the command and status structs between controller and datapath.
`default_nettype none

package npl_pkg;

  localparam int PAYLOAD_BYTES = 5;
  localparam int MAX_SIZE      = PAYLOAD_BYTES - 1;
  localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);

  // Upper three bits of the command byte.
  localparam logic [2:0] OPC_ENTER = 3'b001;
  localparam logic [2:0] OPC_EXIT  = 3'b010;
  localparam logic [2:0] OPC_WRITE = 3'b011;
  localparam logic [2:0] OPC_WSIZE = 3'b100;
  localparam logic [2:0] OPC_REPLY = 3'b110;

  // Decoded operation of the message on the input channel.
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_ENTER = 3'd1;
  localparam logic [2:0] OP_EXIT  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_WSIZE = 3'd4;

  // Register index of the configuration port.
  localparam logic REG_STATION_ID = 1'b0;

  typedef struct packed {
    logic enter;
    logic leave;
    logic load;
    logic emit_write;
    logic emit_reply;
  } npl_cmd_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [CNT_W-1:0] msg_count;
    logic             programming;
    logic             count_one;
    logic             out_free;
  } npl_status_t;

endpackage

`default_nettype wire

>>> rtl/core/npl_msg_if.sv
// Input channel of the network program loader: one six-byte message per
// transfer, with valid and ready. No dependencies.
`default_nettype none

interface npl_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] command;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;
  logic [7:0] byte_four;
  logic [7:0] byte_five;

  modport source (output valid, command, byte_one, byte_two, byte_three, byte_four,
                  byte_five, input ready);
  modport sink (input valid, command, byte_one, byte_two, byte_three, byte_four,
                byte_five, output ready);
endinterface

`default_nettype wire

>>> rtl/core/npl_res_if.sv
// Result channel of the network program loader: one memory write or
// checksum reply per transfer, with valid and ready. No dependencies.
`default_nettype none

interface npl_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] write_address;
  logic [7:0]  write_data;
  logic [7:0]  reply_command;
  logic [15:0] reply_checksum;
  logic        last;

  modport source (output valid, kind, write_address, write_data, reply_command,
                  reply_checksum, last, input ready);
  modport sink (input valid, kind, write_address, write_data, reply_command,
                reply_checksum, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/npl_ctrl.sv
// Controller state machine of the network program loader.
// Depends on npl_pkg and network_program_loader_macros.svh.
`default_nettype none
`include "network_program_loader_macros.svh"

module npl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire npl_pkg::npl_status_t status,
  output npl_pkg::npl_cmd_t         cmd
);
  import npl_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_REPLY = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       write_start;

  assign in_ready    = (state == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign write_start = accept && status.programming && (status.msg_count != '0) &&
                       ((status.op == OP_WRITE) || (status.op == OP_WSIZE));

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (status.op)
            OP_ENTER: cmd.enter = 1'b1;
            OP_EXIT: begin
              cmd.leave  = 1'b1;
              state_next = ST_REPLY;
            end
            OP_WRITE, OP_WSIZE: begin
              if (write_start) begin
                cmd.load   = 1'b1;
                state_next = ST_WRITE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.emit_write = 1'b1;
          if (status.count_one) state_next = ST_IDLE;
        end
      end
      ST_REPLY: begin
        if (status.out_free) begin
          cmd.emit_reply = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `NPL_ASSERT_IMPL(a_write_needs_prog, state == ST_WRITE, status.programming)
  `NPL_ASSERT_NEXT(a_write_starts, write_start, state == ST_WRITE)
  `NPL_ASSERT_NEXT(a_reply_done, state == ST_REPLY && status.out_free, state == ST_IDLE)

endmodule

`default_nettype wire

>>> rtl/core/npl_datapath.sv
// Datapath of the network program loader: message decode, pointer, checksum,
// payload shift register and the output register. Depends on npl_pkg and the macros.
`default_nettype none
`include "network_program_loader_macros.svh"

module npl_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [4:0]          station_id,
  input  wire logic [7:0]          command,
  input  wire logic [7:0]          byte_one,
  input  wire logic [7:0]          byte_two,
  input  wire logic [7:0]          byte_three,
  input  wire logic [7:0]          byte_four,
  input  wire logic [7:0]          byte_five,
  input  wire npl_pkg::npl_cmd_t   cmd,
  output npl_pkg::npl_status_t     status,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     kind,
  output logic [15:0]              write_address,
  output logic [7:0]               write_data,
  output logic [7:0]               reply_command,
  output logic [15:0]              reply_checksum,
  output logic                     last
);
  import npl_pkg::*;

  logic             programming;
  logic [15:0]      write_pointer;
  logic [15:0]      running_sum;
  logic [7:0]       pay [PAYLOAD_BYTES];
  logic [CNT_W-1:0] count;
  logic [2:0]       op;
  logic [CNT_W-1:0] msg_count;
  logic             id_ok;

  always_comb begin
    op = OP_NONE;
    if (command[4:0] == station_id) begin
      case (command[7:5])
        OPC_ENTER: op = OP_ENTER;
        OPC_EXIT:  op = OP_EXIT;
        OPC_WRITE: op = OP_WRITE;
        OPC_WSIZE: op = OP_WSIZE;
        default:   op = OP_NONE;
      endcase
    end
  end

  always_comb begin
    case (op)
      OP_WRITE: msg_count = CNT_W'(PAYLOAD_BYTES);
      OP_WSIZE: msg_count = (byte_one > 8'(MAX_SIZE)) ? CNT_W'(MAX_SIZE)
                                                        : byte_one[CNT_W-1:0];
      default:  msg_count = '0;
    endcase
  end

  assign id_ok = ({byte_one, byte_two} == {11'b0, station_id});

  assign status.op          = op;
  assign status.msg_count   = msg_count;
  assign status.programming = programming;
  assign status.count_one   = (count == CNT_W'(1));
  assign status.out_free    = !out_valid || out_ready;

  // Programming state, pointer and checksum.
  always_ff @(posedge clk) begin
    if (rst) begin
      programming   <= 1'b0;
      write_pointer <= '0;
      running_sum   <= '0;
    end else begin
      if (cmd.enter) begin
        programming <= id_ok;
        if (id_ok) begin
          write_pointer <= {byte_three, byte_four};
          running_sum   <= '0;
        end
      end
      if (cmd.leave) programming <= 1'b0;
      if (cmd.emit_write) begin
        write_pointer <= write_pointer + 16'd1;
        running_sum   <= running_sum + {8'b0, pay[0]};
      end
    end
  end

  // Payload bytes to be written, oldest at the head.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count <= msg_count;
      if (op == OP_WRITE) begin
        pay[0] <= byte_one;
        pay[1] <= byte_two;
        pay[2] <= byte_three;
        pay[3] <= byte_four;
        pay[4] <= byte_five;
      end else begin
        pay[0] <= byte_two;
        pay[1] <= byte_three;
        pay[2] <= byte_four;
        pay[3] <= byte_five;
        pay[4] <= 8'h00;
      end
    end else if (cmd.emit_write) begin
      count <= count - CNT_W'(1);
      for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
        pay[i] <= pay[i+1];
      end
      pay[PAYLOAD_BYTES-1] <= 8'h00;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_write || cmd.emit_reply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_write) begin
      kind           <= 1'b0;
      write_address  <= write_pointer;
      write_data     <= pay[0];
      reply_command  <= 8'h00;
      reply_checksum <= 16'h0000;
      last           <= (count == CNT_W'(1));
    end else if (cmd.emit_reply) begin
      kind           <= 1'b1;
      write_address  <= 16'h0000;
      write_data     <= 8'h00;
      reply_command  <= {OPC_REPLY, station_id};
      reply_checksum <= running_sum;
      last           <= 1'b1;
    end
  end

  `NPL_ASSERT_NEXT(a_write_out, cmd.emit_write,
    out_valid && !kind && write_address == $past(write_pointer))
  `NPL_ASSERT_NEXT(a_reply_out, cmd.emit_reply,
    out_valid && kind && last && reply_checksum == $past(running_sum))

endmodule

`default_nettype wire

>>> rtl/core/network_program_loader.sv
// Top level of the network program loader: configuration register, controller
// and datapath. Depends on npl_pkg, npl_msg_if, npl_res_if, npl_ctrl, npl_datapath.
//
// The loader takes one six-byte network message per transfer on msg and
// produces memory writes and checksum replies on result. A message is taken
// only while the controller is idle. ENTER, unrelated messages and writes
// outside programming mode leave it idle. A WRITE issues one memory write per
// payload byte (five), a WRITE_SIZE as many as its clamped count, and EXIT one
// checksum reply. Results pass through the single output register, which is
// loaded with one result per cycle while the sink keeps up and holds a result
// until the sink takes it, so a stalled sink holds the controller. The last
// result of a message sits in the output register while the next message is
// already accepted. The device id is written through the APB port at byte
// addresses 0 to 3 and reads back there; addresses 4 to 7 read as zero.
`default_nettype none

module network_program_loader (
  input  wire logic        clk,
  input  wire logic        rst,
  npl_msg_if.sink          msg,
  npl_res_if.source        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import npl_pkg::*;

  logic [4:0]  station_id;
  npl_cmd_t    cmd;
  npl_status_t status;

  // The register index is the word address; only the device id exists.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STATION_ID) ? {27'b0, station_id} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_id <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_STATION_ID)) begin
      station_id <= pwdata[4:0];
    end
  end

  npl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (msg.valid),
    .in_ready (msg.ready),
    .status   (status),
    .cmd      (cmd)
  );

  npl_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .station_id     (station_id),
    .command        (msg.command),
    .byte_one       (msg.byte_one),
    .byte_two       (msg.byte_two),
    .byte_three     (msg.byte_three),
    .byte_four      (msg.byte_four),
    .byte_five      (msg.byte_five),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .kind           (result.kind),
    .write_address  (result.write_address),
    .write_data     (result.write_data),
    .reply_command  (result.reply_command),
    .reply_checksum (result.reply_checksum),
    .last           (result.last)
  );

endmodule

`default_nettype wire
